@@ rtl/pcx_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants for the PCX run-length line encoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

   localparam logic [7:0] MARK_BASE = 8'hC0;
   localparam logic [5:0] MAX_CHUNK = 6'h3F;

   localparam logic CSR_COMPRESS_ENABLE = 1'b0;
   localparam logic CSR_INVERT_ENABLE   = 1'b1;

   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      logic [5:0] count;
      logic       split;
   } run_type;

   typedef struct packed {
      run_type first;
      run_type second;
      logic    line_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

@@ rtl/pcx_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_front
// Holds the open run and the control registers, classifies each accepted
// byte and turns it into a command of up to two runs to be written out.
// ----------------------------------------------------------------------------
module pcx_front
   import pcx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic       csr_write_data,
   input  wire logic       req_accept,
   input  wire logic [7:0] req_pixel_byte,
   input  wire logic       req_line_end,
   output cmd_type         cmd,
   output logic            cmd_push
);

   logic       compress_enable_ff;
   logic       invert_enable_ff;
   logic [7:0] run_value_ff, run_value_in;
   logic [5:0] run_count_ff, run_count_in;
   logic       run_was_split_ff, run_was_split_in;

   logic [7:0] pix;
   logic       match;
   logic [5:0] mid_count;
   logic       mid_split;
   logic [7:0] mid_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         compress_enable_ff <= 1'b1;
         invert_enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_COMPRESS_ENABLE: compress_enable_ff <= csr_write_data;
            CSR_INVERT_ENABLE:   invert_enable_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign pix   = invert_enable_ff ? ~req_pixel_byte : req_pixel_byte;
   assign match = (run_count_ff != 6'd0) && (pix == run_value_ff);

   always_comb begin
      cmd              = '0;
      cmd.line_end     = req_line_end;
      mid_count        = run_count_ff;
      mid_split        = run_was_split_ff;
      mid_value        = run_value_ff;
      run_value_in     = run_value_ff;
      run_count_in     = run_count_ff;
      run_was_split_in = run_was_split_ff;
      if (compress_enable_ff) begin
         if (match && (run_count_ff == MAX_CHUNK)) begin
            cmd.first = '{valid: 1'b1, value: run_value_ff, count: MAX_CHUNK, split: 1'b1};
            mid_count = 6'd1;
            mid_split = 1'b1;
         end else if (match) begin
            mid_count = run_count_ff + 6'd1;
         end else begin
            cmd.first = '{valid: (run_count_ff != 6'd0), value: run_value_ff,
                          count: run_count_ff, split: run_was_split_ff};
            mid_count = 6'd1;
            mid_split = 1'b0;
            mid_value = pix;
         end
         if (req_line_end) begin
            cmd.second = '{valid: 1'b1, value: mid_value, count: mid_count, split: mid_split};
            run_count_in     = 6'd0;
            run_was_split_in = 1'b0;
         end else begin
            run_count_in     = mid_count;
            run_was_split_in = mid_split;
         end
         run_value_in = mid_value;
      end else begin
         cmd.first  = '{valid: (run_count_ff != 6'd0), value: run_value_ff,
                        count: run_count_ff, split: run_was_split_ff};
         cmd.second = '{valid: 1'b1, value: pix, count: 6'd1, split: 1'b0};
         run_count_in     = 6'd0;
         run_was_split_in = 1'b0;
      end
   end

   assign cmd_push = req_accept && (cmd.first.valid || cmd.second.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff     <= 8'd0;
         run_count_ff     <= 6'd0;
         run_was_split_ff <= 1'b0;
      end else if (req_accept) begin
         run_value_ff     <= run_value_in;
         run_count_ff     <= run_count_in;
         run_was_split_ff <= run_was_split_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pcx_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_queue
// Small first-in first-out buffer of run commands between front and back.
// ----------------------------------------------------------------------------
module pcx_queue
   import pcx_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  cmd_type         push_data,
   input  wire logic       pop,
   output cmd_type         head,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign status.full  = (fill_ff == CNT_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pcx_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_back
// Takes run commands from the queue and sends their coded bytes one per
// cycle unless stalled, marking the last byte of each input byte and line.
// ----------------------------------------------------------------------------
module pcx_back
   import pcx_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  cmd_type         head,
   input  queue_status_type q_status,
   output logic            pop,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_code_byte,
   output logic            rsp_step_last,
   output logic            rsp_line_done
);

   cmd_type    cur_ff;
   logic [1:0] pos_ff, pos_in;
   logic       busy_ff, busy_in;

   logic [1:0] len0, len1;
   logic [2:0] total;
   logic [1:0] k;
   run_type    sel;
   logic       last;
   logic       take;
   logic       load;

   function automatic logic run_is_pair(run_type r);
      return (r.count != 6'd1) || r.split || ((r.value & MARK_BASE) == MARK_BASE);
   endfunction

   function automatic logic [1:0] run_length(run_type r);
      if (!r.valid) begin
         return 2'd0;
      end
      return run_is_pair(r) ? 2'd2 : 2'd1;
   endfunction

   always_comb begin
      len0  = run_length(cur_ff.first);
      len1  = run_length(cur_ff.second);
      total = {1'b0, len0} + {1'b0, len1};
      if (pos_ff < len0) begin
         sel = cur_ff.first;
         k   = pos_ff;
      end else begin
         sel = cur_ff.second;
         k   = pos_ff - len0;
      end
      if (run_is_pair(sel) && (k == 2'd0)) begin
         rsp_code_byte = MARK_BASE | {2'b00, sel.count};
      end else begin
         rsp_code_byte = sel.value;
      end
      last = ({1'b0, pos_ff} == (total - 3'd1));
   end

   assign rsp_valid     = busy_ff;
   assign rsp_step_last = last;
   assign rsp_line_done = last && cur_ff.line_end;

   assign take = busy_ff && !rsp_stall;
   assign load = !busy_ff || (take && last);
   assign pop  = load && !q_status.empty;

   always_comb begin
      pos_in  = pos_ff;
      busy_in = busy_ff;
      if (load) begin
         pos_in  = 2'd0;
         busy_in = !q_status.empty;
      end else if (take) begin
         pos_in = pos_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         busy_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

endmodule
`default_nettype wire

@@ rtl/pcx_rle_line_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_line_encoder
// PCX run-length encoder for one scan line at a time.
// ----------------------------------------------------------------------------
// One raw byte is taken per transaction on the req_ channel, and every
// cycle while the command queue has room. Each input byte gives 0 to 4
// coded bytes on the rsp_ channel; the output stage sends one coded byte
// per cycle while it has bytes and rsp_stall is low (0 bytes when an input
// byte only extends a run, 2 for a typical run pair, 4 when a full 63-byte
// chunk and a split remainder are both closed). QUEUE_DEPTH commands absorb
// bursts; req_stall rises when the queue is full. With the path empty, a
// byte's command is queued, then loaded into the output register driving rsp_.
// Configuration is written on csr_: index 0 is compress enable, 1 is invert.
// ----------------------------------------------------------------------------
module pcx_rle_line_encoder
   import pcx_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_index,
   input  wire logic       csr_write_data,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_pixel_byte,
   input  wire logic       req_line_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_code_byte,
   output logic            rsp_step_last,
   output logic            rsp_line_done
);

   cmd_type          cmd;
   cmd_type          head;
   logic             q_push;
   logic             q_pop;
   queue_status_type q_status;
   logic             req_accept;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid && !req_stall;

   pcx_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_accept),
      .req_pixel_byte   (req_pixel_byte),
      .req_line_end     (req_line_end),
      .cmd              (cmd),
      .cmd_push         (q_push)
   );

   pcx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (cmd),
      .pop       (q_pop),
      .head      (head),
      .status    (q_status)
   );

   pcx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_byte (rsp_code_byte),
      .rsp_step_last (rsp_step_last),
      .rsp_line_done (rsp_line_done)
   );

   // output side is idle right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a queued command is either still queued or being sent
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      q_push |=> (rsp_valid || !q_status.empty))
      else $error("pushed command lost");

   // bytes of one input byte go out without a gap
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_step_last) |=> rsp_valid)
      else $error("gap inside one transaction's bytes");

   // line end marks only the closing byte of a transaction
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_done) |-> rsp_step_last)
      else $error("line_done without step_last");

endmodule
`default_nettype wire
